// ===== design/assert_macros.svh =====
// Concurrent assertion helpers; the bodies are empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge, off while reset is asserted.
`define I3_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property failed");
// Check that a condition never holds on a rising edge.
`define I3_NEVER(lbl, clk, rst_n, cond) \
	`I3_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define I3_ASSERT(lbl, clk, rst_n, prop)
`define I3_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== design/i3gdp_pkg.sv =====
`timescale 1ns / 1ps
package i3gdp_pkg;
	localparam int SUM_WIDTH   = 25;
	localparam int CODE_BITS   = 3;
	localparam int CODE_BIAS   = 4;
	localparam int LO_BITS     = CODE_BITS - 1;
	localparam int OUT_TDATA_W = ((SUM_WIDTH + 7) / 8) * 8;

	typedef logic signed [SUM_WIDTH-1:0] sum_t;

	typedef struct packed {
		logic valid;
		logic last;
	} beat_ctl_t;
endpackage

// ===== design/i3gdp_lane.sv =====
`timescale 1ns / 1ps
module i3gdp_lane #(
	parameter int ACT_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [i3gdp_pkg::LO_BITS-1:0]         lo_code,
	input  logic                                  hi_bit,
	input  logic signed [ACT_WIDTH-1:0]           act,
	output i3gdp_pkg::sum_t                       prod_s1
);
	localparam int PW = ACT_WIDTH + i3gdp_pkg::CODE_BITS + 1;

	logic signed [i3gdp_pkg::CODE_BITS:0] weight;
	logic signed [PW-1:0]                 prod;
	i3gdp_pkg::sum_t                      prod_ext;

	// decode the biased code into -4..3
	assign weight = $signed({1'b0, hi_bit, lo_code})
		- $signed((i3gdp_pkg::CODE_BITS + 1)'(i3gdp_pkg::CODE_BIAS));
	assign prod = weight * act;

	generate
		if (PW >= i3gdp_pkg::SUM_WIDTH) begin : g_trunc
			// the sum wraps modulo 2^SUM_WIDTH, so drop the high bits
			assign prod_ext = prod[i3gdp_pkg::SUM_WIDTH-1:0];
		end else begin : g_ext
			assign prod_ext = {{(i3gdp_pkg::SUM_WIDTH - PW){prod[PW-1]}}, prod};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_ext;
		end
	end
endmodule

// ===== design/i3gdp_merge.sv =====
`timescale 1ns / 1ps
module i3gdp_merge #(
	parameter int LANES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  i3gdp_pkg::beat_ctl_t  in_ctl,
	output logic                  in_ready,
	input  i3gdp_pkg::sum_t       leaf_in [LANES],
	output i3gdp_pkg::beat_ctl_t  out_ctl,
	input  logic                  out_ready,
	output i3gdp_pkg::sum_t       sum_out
);
	// at least one adder level, so a single lane still has a tree of two leaves
	localparam int NLVL = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int P    = 1 << NLVL;

	i3gdp_pkg::sum_t leaf   [P];
	i3gdp_pkg::sum_t node_q [P-1];
	logic [NLVL-1:0] vld_q;
	logic [NLVL-1:0] last_q;
	logic [NLVL-1:0] rdy;
	logic [NLVL-1:0] src_v;
	logic [NLVL-1:0] src_last;
	logic [NLVL-1:0] load;

	genvar j, d, k;
	generate
		for (j = 0; j < P; j++) begin : g_leaf
			if (j < LANES) begin : g_used
				assign leaf[j] = leaf_in[j];
			end else begin : g_pad
				assign leaf[j] = '0;
			end
		end

		// depth 0 is the root; depth NLVL-1 adds pairs of leaves
		for (d = 0; d < NLVL; d++) begin : g_lvl
			if (d == NLVL - 1) begin : g_src_in
				assign src_v[d]    = in_ctl.valid;
				assign src_last[d] = in_ctl.last;
			end else begin : g_src_lvl
				assign src_v[d]    = vld_q[d+1];
				assign src_last[d] = last_q[d+1];
			end

			if (d == 0) begin : g_rdy_root
				assign rdy[d] = !vld_q[d] || out_ready;
			end else begin : g_rdy_lvl
				assign rdy[d] = !vld_q[d] || rdy[d-1];
			end

			assign load[d] = rdy[d] && src_v[d];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[d]  <= 1'b0;
					last_q[d] <= 1'b0;
				end else if (rdy[d]) begin
					vld_q[d]  <= src_v[d];
					last_q[d] <= src_last[d];
				end
			end

			for (k = 0; k < (1 << d); k++) begin : g_node
				localparam int N = (1 << d) - 1 + k;
				localparam int C = 2 * N + 1;
				if (d == NLVL - 1) begin : g_from_leaf
					always_ff @(posedge clk) begin
						if (load[d]) begin
							node_q[N] <= leaf[C-(P-1)] + leaf[C+1-(P-1)];
						end
					end
				end else begin : g_from_node
					always_ff @(posedge clk) begin
						if (load[d]) begin
							node_q[N] <= node_q[C] + node_q[C+1];
						end
					end
				end
			end
		end
	endgenerate

	assign in_ready      = rdy[NLVL-1];
	assign out_ctl.valid = vld_q[0];
	assign out_ctl.last  = last_q[0];
	assign sum_out       = node_q[0];
endmodule

// ===== design/int3_group_dot_product.sv =====
// int3_group_dot_product: dot product of 3-bit weights with Q3.12 activations.
// Slave channel s_*: one beat carries LANES weights (low code plane, high bit
// plane) and LANES activations; s_tlast marks the final beat of a weight group.
// Master channel m_*: one beat per group, the exact group sum with 12 fraction
// bits, sent after the beat that carried s_tlast. Other beats give no output.
// Throughput: one input beat per cycle, sustained while results are taken
// on m_tready; every lane multiplies in the same cycle and the merge tree
// is pipelined, one adder level per stage. The sum of an s_tlast beat
// reaches m_tvalid through the lane register, each adder tree level (one
// adder level for a single lane) and the output register.
// Stall: each stage has its own valid bit, so input beats keep entering empty
// stages while a finished sum waits on m_tready; s_tready drops only once the
// whole pipe is full behind a held result. The result holds until taken.
// Reset (arst_n low): all valid bits and the running sum clear at once; the
// block is ready for beats as soon as reset is released.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module int3_group_dot_product #(
	parameter int LANES     = 8,
	parameter int ACT_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// lo_codes[2*LANES], hi_bits[LANES], act_0..act_(LANES-1)[ACT_WIDTH each]
	input  logic [((3*LANES + LANES*ACT_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic                                  s_tlast,  // group_end
	// dot_sum[25]
	output logic [i3gdp_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready
);
	localparam int LO_W   = i3gdp_pkg::LO_BITS * LANES;
	localparam int ACT_LO = LO_W + LANES;

	// lane stage
	logic                 v_s1;
	logic                 last_s1;
	i3gdp_pkg::sum_t      prod_s1 [LANES];
	logic                 tree_in_ready;
	logic                 s_take;

	// merge tree output and accumulator
	i3gdp_pkg::beat_ctl_t lane_ctl;
	i3gdp_pkg::beat_ctl_t root_ctl;
	i3gdp_pkg::sum_t      root_sum;
	i3gdp_pkg::sum_t      acc_q;
	i3gdp_pkg::sum_t      sum_next;
	i3gdp_pkg::sum_t      dout_q;
	logic                 m_tvalid_q;
	logic                 acc_ready;
	logic                 acc_take;

	assign s_tready = !v_s1 || tree_in_ready;
	assign s_take   = s_tvalid && s_tready;

	// one multiplier per element, all loaded by the same accepted beat
	genvar i;
	generate
		for (i = 0; i < LANES; i++) begin : g_lane
			i3gdp_lane #(
				.ACT_WIDTH (ACT_WIDTH)
			) u_lane (
				.clk     (clk),
				.en      (s_take),
				.lo_code (s_tdata[i3gdp_pkg::LO_BITS*i +: i3gdp_pkg::LO_BITS]),
				.hi_bit  (s_tdata[LO_W + i]),
				.act     ($signed(s_tdata[ACT_LO + ACT_WIDTH*i +: ACT_WIDTH])),
				.prod_s1 (prod_s1[i])
			);
		end
	endgenerate

	// the lane stage holds its beat until the tree takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1    <= s_tvalid;
			last_s1 <= s_tlast;
		end
	end

	assign lane_ctl.valid = v_s1;
	assign lane_ctl.last  = last_s1;

	i3gdp_merge #(
		.LANES (LANES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (lane_ctl),
		.in_ready  (tree_in_ready),
		.leaf_in   (prod_s1),
		.out_ctl   (root_ctl),
		.out_ready (acc_ready),
		.sum_out   (root_sum)
	);

	// A mid-group beat only adds into the running sum and is always taken;
	// a group-end beat needs the output register free (or emptying now).
	assign acc_ready = !root_ctl.last || !m_tvalid_q || m_tready;
	assign acc_take  = root_ctl.valid && acc_ready;
	assign sum_next  = acc_q + root_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (acc_take) begin
				// clear at group end so the next group starts from zero
				acc_q <= root_ctl.last ? '0 : sum_next;
			end
			if (acc_take && root_ctl.last) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload: load on group end, hold otherwise
	always_ff @(posedge clk) begin
		if (acc_take && root_ctl.last) begin
			dout_q <= sum_next;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(i3gdp_pkg::OUT_TDATA_W - i3gdp_pkg::SUM_WIDTH){1'b0}}, dout_q};

	// running sum restarts from zero after every emitted group
	`I3_ASSERT(a_acc_clear, clk, arst_n, (acc_take && root_ctl.last) |=> (acc_q == '0))
	// a result appears only from a group-end beat leaving the tree
	`I3_ASSERT(a_out_src, clk, arst_n, $rose(m_tvalid_q) |-> $past(acc_take && root_ctl.last))
	// the emitted sum is the accumulator plus the final beat's products
	`I3_ASSERT(a_out_val, clk, arst_n, (acc_take && root_ctl.last) |=> (dout_q == $past(sum_next)))
	// a lane beat the tree cannot take yet stays in the lane stage
	`I3_ASSERT(a_lane_hold, clk, arst_n, (v_s1 && !tree_in_ready) |=> v_s1)
endmodule
